[rtl/csa_pkg.sv]
// Shared types and constants for the contiguous slot allocator.
package csa_pkg;

   localparam int SLOTS_DEFAULT = 64;

   localparam int TYPE_W   = 2;
   localparam int FIRST_W  = 6;
   localparam int COUNT_W  = 7;
   localparam int STATUS_W = 2;
   localparam int BASE_W   = 6;
   localparam int LIMIT_W  = 7;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

   localparam logic [TYPE_W-1:0] REQ_ALLOC = 2'd0;
   localparam logic [TYPE_W-1:0] REQ_FREE  = 2'd1;
   localparam logic [TYPE_W-1:0] REQ_CLEAR = 2'd2;
   localparam logic [TYPE_W-1:0] REQ_NONE  = 2'd3;

   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NOSPACE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD     = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_UNUSED  = 2'd3;

   typedef struct packed {
      logic [TYPE_W-1:0]  req_type;
      logic [FIRST_W-1:0] first_slot;
      logic [COUNT_W-1:0] slot_count;
   } req_item_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [BASE_W-1:0]   base_slot;
   } rsp_item_type;

endpackage

[rtl/contiguous_slot_allocator_top.sv]
// First-fit contiguous slot allocator over a rotating occupancy bitmap.
//
// Request channel: a transaction is taken at a clock edge with start high and
// busy low. req_data carries the type (allocate, free, clear), first slot and
// count. Exactly one response per transaction appears on rsp_data for one
// cycle, flagged by rsp_valid; the receiver has no way to stall it.
// Configuration: csr_wr_en writes csr_wr_data into the managed-slot limit; the user
// writes only while busy is low and no response is outstanding, which the block does not enforce.
// Sequencing: clear, zero-length allocate, out-of-range free, zero-length free
// and unknown types respond in the cycle after acceptance without going busy.
// Allocate and free rotate the bitmap one slot per cycle through a check pass
// over all SLOTS positions, and on success a second pass that writes the run;
// the response is registered as the last pass ends. The bitmap is a shift
// register scanned one bit at a time, and a new request is taken the cycle
// the response shows.
// Reset: bitmap cleared to all free, limit set to 64, no response pending.
module contiguous_slot_allocator_top
   import csa_pkg::*;
#(
   parameter int SLOTS = SLOTS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  req_item_type       req_data,
   input  logic               csr_wr_en,
   input  logic [LIMIT_W-1:0] csr_wr_data,
   output logic               rsp_valid,
   output rsp_item_type       rsp_data
);

   localparam int POS_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CMP_W = (POS_W + 1 > 8) ? POS_W + 1 : 8;
   localparam logic [POS_W-1:0] POS_LAST  = POS_W'(SLOTS - 1);
   localparam logic [CMP_W-1:0] SLOTS_CMP = CMP_W'(SLOTS);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_SCAN  = 2'd1;
   localparam logic [1:0] S_APPLY = 2'd2;

   logic [1:0]         state_ff, state_in;
   logic [SLOTS-1:0]   map_ff, map_in, map_rot;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [LIMIT_W-1:0] limit_ff, limit_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_item_type       rsp_data_ff, rsp_data_in;

   logic [TYPE_W-1:0]  op_ff, op_in;
   logic [CMP_W-1:0]   cnt_ff, cnt_in;
   logic [CMP_W-1:0]   lo_ff, lo_in;
   logic [CMP_W-1:0]   hi_ff, hi_in;
   logic [CMP_W-1:0]   run_len_ff, run_len_in;
   logic               found_ff, found_in;
   logic               bad_ff, bad_in;

   logic [CMP_W-1:0]   lim;
   logic [CMP_W-1:0]   pos_cmp;
   logic [CMP_W-1:0]   req_cnt, req_first, req_end;
   logic [CMP_W-1:0]   run_next;
   logic               in_run;
   logic               new_bit;
   logic               pass_end;
   logic               scan_ok;

   // Rotate right: bit 0 always holds the slot numbered pos_ff.
   generate
      if (SLOTS > 1) begin : g_rot
         assign map_rot = {new_bit, map_ff[SLOTS-1:1]};
      end else begin : g_rot_one
         assign map_rot = new_bit;
      end
   endgenerate

   always_comb begin
      lim       = (CMP_W'(limit_ff) > SLOTS_CMP) ? SLOTS_CMP : CMP_W'(limit_ff);
      pos_cmp   = CMP_W'(pos_ff);
      req_cnt   = CMP_W'(req_data.slot_count);
      req_first = CMP_W'(req_data.first_slot);
      req_end   = req_first + req_cnt;
      run_next  = run_len_ff + 1'b1;
      in_run    = (pos_cmp >= lo_ff) && (pos_cmp < hi_ff);
      pass_end  = (pos_ff == POS_LAST);

      state_in     = state_ff;
      map_in       = map_ff;
      pos_in       = pos_ff;
      limit_in     = csr_wr_en ? csr_wr_data : limit_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      op_in        = op_ff;
      cnt_in       = cnt_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      run_len_in   = run_len_ff;
      found_in     = found_ff;
      bad_in       = bad_ff;
      new_bit      = map_ff[0];
      scan_ok      = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in      = req_data.req_type;
               cnt_in     = req_cnt;
               lo_in      = req_first;
               hi_in      = req_end;
               run_len_in = '0;
               found_in   = 1'b0;
               bad_in     = 1'b0;
               pos_in     = '0;
               rsp_data_in.base_slot = '0;
               case (req_data.req_type)
                  REQ_ALLOC: begin
                     if (req_cnt == '0) begin
                        rsp_valid_in       = 1'b1;
                        rsp_data_in.status = STATUS_OK;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  REQ_FREE: begin
                     if (req_end > lim) begin
                        rsp_valid_in       = 1'b1;
                        rsp_data_in.status = STATUS_BAD;
                     end else if (req_cnt == '0) begin
                        rsp_valid_in       = 1'b1;
                        rsp_data_in.status = STATUS_OK;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  REQ_CLEAR: begin
                     map_in             = '0;
                     rsp_valid_in       = 1'b1;
                     rsp_data_in.status = STATUS_OK;
                  end
                  default: begin
                     rsp_valid_in       = 1'b1;
                     rsp_data_in.status = STATUS_BAD;
                  end
               endcase
            end
         end

         S_SCAN: begin
            map_in = map_rot;
            pos_in = pass_end ? '0 : pos_ff + 1'b1;
            if (op_ff == REQ_ALLOC) begin
               if (!found_ff && (pos_cmp < lim)) begin
                  if (!map_ff[0]) begin
                     run_len_in = run_next;
                     if (run_len_ff == '0) begin
                        lo_in = pos_cmp;
                     end
                     if (run_next == cnt_ff) begin
                        found_in = 1'b1;
                        hi_in    = pos_cmp + 1'b1;
                     end
                  end else begin
                     run_len_in = '0;
                  end
               end
               scan_ok = found_in;
            end else begin
               if (in_run && !map_ff[0]) begin
                  bad_in = 1'b1;
               end
               scan_ok = !bad_in;
            end
            if (pass_end) begin
               if (scan_ok) begin
                  state_in = S_APPLY;
               end else begin
                  state_in              = S_IDLE;
                  rsp_valid_in          = 1'b1;
                  rsp_data_in.base_slot = '0;
                  rsp_data_in.status    = (op_ff == REQ_ALLOC) ? STATUS_NOSPACE : STATUS_BAD;
               end
            end
         end

         S_APPLY: begin
            if (in_run) begin
               new_bit = (op_ff == REQ_ALLOC);
            end
            map_in = map_rot;
            pos_in = pass_end ? '0 : pos_ff + 1'b1;
            if (pass_end) begin
               state_in           = S_IDLE;
               rsp_valid_in       = 1'b1;
               rsp_data_in.status = STATUS_OK;
               rsp_data_in.base_slot =
                  (op_ff == REQ_ALLOC) ? lo_ff[BASE_W-1:0] : '0;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         map_ff       <= '0;
         pos_ff       <= '0;
         limit_ff     <= LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         map_ff       <= map_in;
         pos_ff       <= pos_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      op_ff       <= op_in;
      cnt_ff      <= cnt_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      run_len_ff  <= run_len_in;
      found_ff    <= found_in;
      bad_ff      <= bad_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[rtl/csa_checker.sv]
// Port-level checks for the slot allocator, bound to its top level.
module csa_checker
   import csa_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         start,
   input logic         busy,
   input logic         rsp_valid,
   input rsp_item_type rsp_data
);

   // An accepted transaction either answers at once or holds busy.
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (rsp_valid || busy))
      else $error("accepted transaction neither answered nor busy");

   // Leaving the busy states always delivers the response in the same cycle.
   a_fell_busy_rsp: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid)
      else $error("busy dropped without a response");

   // No response without a transaction behind it.
   a_rsp_has_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(start && !busy) || $fell(busy)))
      else $error("response without a matching transaction");

   // Only a successful response may carry a nonzero base.
   a_base_only_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.status != STATUS_OK)) |-> (rsp_data.base_slot == '0))
      else $error("nonzero base on a failed response");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.status != STATUS_UNUSED))
      else $error("response status outside the defined codes");

endmodule

bind contiguous_slot_allocator_top csa_checker u_csa_checker (.*);
